[sv/dcrc_pkg.sv]
// Package: shared types, constants and CRC-16 step functions for the dual CRC checker.
package dcrc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 16;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

    // Result of one accepted byte, handed from the CRC engine to the result stage
    typedef struct packed {
        logic             fire;       // last byte accepted this cycle
        logic [CRC_W-1:0] fwd_crc;    // MSB-first CRC over the message
        logic [CRC_W-1:0] refl_crc;   // reflected-in, reflected-out CRC
        logic [CRC_W-1:0] reference;  // expected CRC sampled with the last byte
    } dcrc_step_t;

    // Eight MSB-first polynomial steps over one byte
    function automatic logic [CRC_W-1:0] crc16_byte(
        input logic [CRC_W-1:0]  rem,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] r;
        r = rem ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if (r[CRC_W-1]) begin
                r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Bit reversal of a byte
    function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    // Bit reversal of a 16-bit word
    function automatic logic [CRC_W-1:0] reverse16(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

endpackage

[sv/dcrc_if.sv]
// Interfaces: byte input channel and CRC result channel.
interface dcrc_msg_if;
    logic                          valid;
    logic                          ready;
    logic [dcrc_pkg::BYTE_W-1:0]   data_byte;
    logic                          last_byte;
    logic [dcrc_pkg::CRC_W-1:0]    reference_crc;

    modport source (output valid, output data_byte, output last_byte,
                    output reference_crc, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input reference_crc, output ready);
endinterface

interface dcrc_res_if;
    logic                          valid;
    logic                          ready;
    logic [dcrc_pkg::CRC_W-1:0]    crc_msb_first;
    logic [dcrc_pkg::CRC_W-1:0]    crc_reflected;
    logic                          ref_match;

    modport source (output valid, output crc_msb_first, output crc_reflected,
                    output ref_match, input ready);
    modport sink   (input valid, input crc_msb_first, input crc_reflected,
                    input ref_match, output ready);
endinterface

[sv/dcrc_engine.sv]
// CRC engine: holds both running remainders and advances them by one byte per transfer.
module dcrc_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    dcrc_msg_if.sink             msg,
    input  logic                 slot_free,
    output dcrc_pkg::dcrc_step_t step
);
    import dcrc_pkg::*;

    logic [CRC_W-1:0] fwd_reg,  fwd_next;
    logic [CRC_W-1:0] refl_reg, refl_next;
    logic [CRC_W-1:0] fwd_upd,  refl_upd;
    logic             accept;

    // Byte is taken whenever the result slot can absorb a possible result
    assign msg.ready = slot_free;
    assign accept    = msg.valid && slot_free;

    // Both remainders advance by one byte; the second sees the byte reversed
    assign fwd_upd  = crc16_byte(fwd_reg, msg.data_byte);
    assign refl_upd = crc16_byte(refl_reg, reverse8(msg.data_byte));

    always_comb
    begin
        fwd_next  = fwd_reg;
        refl_next = refl_reg;
        if (accept) begin
            if (msg.last_byte) begin
                fwd_next  = CRC_INIT;
                refl_next = CRC_INIT;
            end else begin
                fwd_next  = fwd_upd;
                refl_next = refl_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fwd_reg  <= CRC_INIT;
            refl_reg <= CRC_INIT;
        end else begin
            fwd_reg  <= fwd_next;
            refl_reg <= refl_next;
        end
    end

    // Finished message handed to the result stage
    assign step.fire      = accept && msg.last_byte;
    assign step.fwd_crc   = fwd_upd;
    assign step.refl_crc  = reverse16(refl_upd);
    assign step.reference = msg.reference_crc;

    // Remainders start afresh after every last byte
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && msg.last_byte |=> fwd_reg == CRC_INIT && refl_reg == CRC_INIT)
        else $error("remainders not cleared after last byte");

    // No transfer, no change of state
    a_hold_without_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(fwd_reg) && $stable(refl_reg))
        else $error("remainder changed without a transfer");

    // A message byte that is not last advances the forward remainder
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !msg.last_byte |=> fwd_reg == $past(fwd_upd))
        else $error("forward remainder did not advance");

endmodule

[sv/dcrc_result.sv]
// Result stage: compares against the reference and holds the result until it is taken.
module dcrc_result (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dcrc_pkg::dcrc_step_t step,
    output logic                 slot_free,
    dcrc_res_if.source           res
);
    import dcrc_pkg::*;

    logic             valid_reg,  valid_next;
    logic [CRC_W-1:0] fwd_reg;
    logic [CRC_W-1:0] refl_reg;
    logic             match_reg;
    logic             match;

    // Slot is free when empty or being emptied this cycle
    assign slot_free = !valid_reg || res.ready;

    assign match = (step.fwd_crc == step.reference) || (step.refl_crc == step.reference);

    always_comb
    begin
        valid_next = valid_reg;
        if (step.fire) begin
            valid_next = 1'b1;
        end else if (res.ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, loaded only with a finished message
    always_ff @(posedge clk)
    begin
        if (step.fire) begin
            fwd_reg   <= step.fwd_crc;
            refl_reg  <= step.refl_crc;
            match_reg <= match;
        end
    end

    assign res.valid         = valid_reg;
    assign res.crc_msb_first = fwd_reg;
    assign res.crc_reflected = refl_reg;
    assign res.ref_match     = match_reg;

    // A finished message is always presented next cycle
    a_fire_presents: assert property (@(posedge clk) disable iff (!rst_n)
        step.fire |=> valid_reg)
        else $error("result not presented after last byte");

    // A result is never overwritten while still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        step.fire |-> slot_free)
        else $error("result overwritten before transfer");

    // Slot only empties through a transfer
    a_empty_by_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(valid_reg) |-> $past(res.ready))
        else $error("result dropped without a transfer");

endmodule

[sv/dual_crc16_8005_check.sv]
// Top level: dual CRC-16 (poly 0x8005) message checker, BUYPASS and ARC side by side.
//
//   channel  | dir | payload                                         | transfer
//   msg      | in  | data_byte[7:0], last_byte, reference_crc[15:0] | one message byte
//   result   | out | crc_msb_first[15:0], crc_reflected[15:0],      | one per message,
//            |     | ref_match                                       | after last byte
//
// One byte per cycle while msg.ready is high; the eight CRC bit steps per byte sit
// between the remainder and result registers; the result appears in the cycle after
// the last byte. Reset clears both remainders and empties the result register.
// msg.ready is low only while a result waits and result.ready is low; a held result
// does not block bytes once it is being taken in the same cycle.
module dual_crc16_8005_check (
    input  logic       clk,
    input  logic       rst_n,
    dcrc_msg_if.sink   msg,
    dcrc_res_if.source result
);
    import dcrc_pkg::*;

    dcrc_step_t step;
    logic       slot_free;

    // Running remainders
    dcrc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .slot_free (slot_free),
        .step      (step)
    );

    // Reference compare and result register
    dcrc_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .slot_free (slot_free),
        .res       (result)
    );

endmodule

[bench/dual_crc16_8005_check_tb.sv]
// Testbench for the dual CRC-16 (poly 0x8005) checker: directed rows, random messages, scoreboard.
module dual_crc16_8005_check_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dcrc_pkg::*;

    localparam int          ITEM_TARGET  = 1100;
    localparam int          IDLE_PERCENT = 29;
    localparam int          STALL_LEN    = 200;
    localparam int          STALL_AT     = 300;
    localparam int          STEADY_END   = 520;
    localparam int          MAX_REPORTS  = 10;
    localparam int          DRAIN_CYCLES = 8;
    // Bit-reversed 0x8005, for the LSB-first form of the reflected CRC
    localparam logic [15:0] REFL_POLY    = 16'hA001;

    typedef struct packed {
        logic [CRC_W-1:0] fwd;
        logic [CRC_W-1:0] refl;
        logic             match;
    } crc_result_t;

    // One row of the directed part; known rows carry a typed-in result
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [CRC_W-1:0]  ref_crc;
        logic              known;
        logic [CRC_W-1:0]  fwd;
        logic [CRC_W-1:0]  refl;
        logic              match;
    } stim_row_t;

    localparam int N_ROWS = 25;

    // "123456789" gives the published check values: 0xFEE8 MSB-first, 0xBB3D reflected
    stim_row_t stim_rows [0:N_ROWS-1] = '{
        '{8'h00, 1'b1, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b1},
        '{8'h00, 1'b1, 16'hFFFF, 1'b1, 16'h0000, 16'h0000, 1'b0},
        '{8'h31, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h32, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h33, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h34, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h35, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h36, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h37, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h38, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h39, 1'b1, 16'hBB3D, 1'b1, 16'hFEE8, 16'hBB3D, 1'b1},
        '{8'h31, 1'b0, 16'hBB3D, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h32, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h33, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h34, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h35, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h36, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h37, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h38, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h39, 1'b1, 16'hFEE8, 1'b1, 16'hFEE8, 16'hBB3D, 1'b1},
        '{8'hFF, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h01, 1'b1, 16'h8005, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h55, 1'b0, 16'hAAAA, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'hAA, 1'b1, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0}
    };

    logic clk;
    logic rst_n;

    dcrc_msg_if msg_ch ();
    dcrc_res_if res_ch ();

    dual_crc16_8005_check dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .result (res_ch)
    );

    // Predictor state: MSB-first remainder and LSB-first reflected remainder
    logic [CRC_W-1:0] fwd_rem;
    logic [CRC_W-1:0] refl_rem;

    crc_result_t pending_crcs [$];
    int          error_count;
    int          items_sent;
    bit          steady;
    bit          stall_request;

    // MSB-first CRC over one byte, one bit at a time
    function automatic logic [CRC_W-1:0] fwd_advance(input logic [CRC_W-1:0] rem,
                                                     input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        logic             fb;
        r = rem;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = r[CRC_W-1] ^ b[i];
            r  = r << 1;
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Reflected CRC run LSB-first with the reversed polynomial; no final reversal needed
    function automatic logic [CRC_W-1:0] refl_advance(input logic [CRC_W-1:0] rem,
                                                      input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        logic             fb;
        r = rem;
        for (int i = 0; i < BYTE_W; i++) begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb)
            begin
                r = r ^ REFL_POLY;
            end
        end
        return r;
    endfunction

    // Advance both remainders; on the last byte return the result and clear
    function automatic crc_result_t absorb_byte(input logic [BYTE_W-1:0] b, input logic l,
                                                input logic [CRC_W-1:0] r);
        crc_result_t res;
        fwd_rem   = fwd_advance(fwd_rem, b);
        refl_rem  = refl_advance(refl_rem, b);
        res.fwd   = fwd_rem;
        res.refl  = refl_rem;
        res.match = (fwd_rem == r) || (refl_rem == r);
        if (l)
        begin
            fwd_rem  = '0;
            refl_rem = '0;
        end
        return res;
    endfunction

    // Offer one byte, after a random gap unless steady; log the expected result when a last byte transfers
    task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic l,
                              input logic [CRC_W-1:0] r, input crc_result_t res);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid         <= 1'b1;
        msg_ch.data_byte     <= b;
        msg_ch.last_byte     <= l;
        msg_ch.reference_crc <= r;
        @(posedge clk);
        while (!msg_ch.ready)
        begin
            @(posedge clk);
        end
        if (l)
        begin
            pending_crcs.push_back(res);
        end
        items_sent++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset, held low at the start
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    // Sender: directed rows, then random messages, then drain
    initial
    begin
        crc_result_t       res;
        logic [BYTE_W-1:0] b;
        logic              l;
        logic [CRC_W-1:0]  r;
        int                len;
        int                pick;

        msg_ch.valid         <= 1'b0;
        msg_ch.data_byte     <= '0;
        msg_ch.last_byte     <= 1'b0;
        msg_ch.reference_crc <= '0;
        fwd_rem       = '0;
        refl_rem      = '0;
        error_count   = 0;
        items_sent    = 0;
        steady        = 1'b0;
        stall_request = 1'b0;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed part
        for (int i = 0; i < N_ROWS; i++) begin
            res = absorb_byte(stim_rows[i].data, stim_rows[i].last, stim_rows[i].ref_crc);
            if (stim_rows[i].known)
            begin
                res = '{stim_rows[i].fwd, stim_rows[i].refl, stim_rows[i].match};
            end
            offer_byte(stim_rows[i].data, stim_rows[i].last, stim_rows[i].ref_crc, res);
        end

        // Random messages; mostly short, a few long
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 8);
            else if (pick < 95)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(25, 64);

            for (int k = 0; k < len; k++) begin
                // Long receiver stall, with the sender offering back to back around it
                if (items_sent >= STALL_AT)
                    stall_request = 1'b1;
                steady = (items_sent >= STALL_AT) && (items_sent < STEADY_END);

                b = BYTE_W'($urandom_range(0, 255));
                l = (k == len - 1);
                r = CRC_W'($urandom_range(0, 65535));
                // Aim the reference at one CRC or the other in most messages
                if (l)
                begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        r = fwd_advance(fwd_rem, b);
                    else if (pick == 1)
                        r = refl_advance(refl_rem, b);
                end
                res = absorb_byte(b, l, r);
                offer_byte(b, l, r, res);
            end
        end
        steady = 1'b0;
        msg_ch.valid <= 1'b0;

        // Drain, then keep watching to catch stray results
        while (pending_crcs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_crcs.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Receiver: random back-pressure plus one long hold-off
    initial
    begin
        int  stall_left;
        bit  stall_taken;
        stall_left  = 0;
        stall_taken = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_request && !stall_taken)
            begin
                stall_taken = 1'b1;
                stall_left  = STALL_LEN;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Scoreboard: each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        crc_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_crcs.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: fwd %h refl %h match %b",
                             res_ch.crc_msb_first, res_ch.crc_reflected, res_ch.ref_match);
            end
            else
            begin
                want = pending_crcs.pop_front();
                if (res_ch.crc_msb_first !== want.fwd || res_ch.crc_reflected !== want.refl
                    || res_ch.ref_match !== want.match)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: fwd %h/%h refl %h/%h match %b/%b (exp/act)",
                                 want.fwd, res_ch.crc_msb_first,
                                 want.refl, res_ch.crc_reflected,
                                 want.match, res_ch.ref_match);
                end
            end
        end
    end

endmodule
